[hw/rtl/kyoq_pkg.sv]
`default_nettype none

package kyoq_pkg;

  // Width of one zero padded name: eight low bytes and one high byte
  localparam int KEY_LOW_W  = 64;
  localparam int KEY_HIGH_W = 8;
  localparam int KEY_W      = KEY_LOW_W + KEY_HIGH_W;

  // Result field widths
  localparam int OP_W  = 2;
  localparam int POS_W = 4;
  localparam int OCC_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

endpackage

`default_nettype wire

[hw/rtl/kyoq_in_if.sv]
`default_nettype none

interface kyoq_in_if import kyoq_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       op;
  logic [KEY_LOW_W-1:0]  key_low;
  logic [KEY_HIGH_W-1:0] key_high;

  modport source (output valid, output op, output key_low, output key_high, input ready);
  modport sink   (input valid, input op, input key_low, input key_high, output ready);
endinterface

`default_nettype wire

[hw/rtl/kyoq_out_if.sv]
`default_nettype none

interface kyoq_out_if import kyoq_pkg::*;;
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [POS_W-1:0] position;
  logic [OCC_W-1:0] occupancy;

  modport source (output valid, output status, output position, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input position, input occupancy,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/keyed_ordered_queue.sv]
`default_nettype none

// Ordered queue of up to QUEUE_DEPTH 72-bit keys held in one synchronous
// RAM (one read and one write port, read data registered). Append writes at
// the tail; remove and query scan from the head one entry per cycle, and
// remove then closes the gap by copying each later entry down one place, one
// entry per cycle. Every transaction on in_ch yields exactly one transaction
// on out_ch. A scan reads the entries up to and including the first match,
// or all n held entries when no key matches (none on an empty queue); a
// remove then moves down the n - p - 1 entries behind the matched position p.
// in_ch.ready is high only in the idle state, which the block enters as the
// previous result moves into the output register; one finished result may
// wait there while the next operation runs. The RAM needs no clearing after
// reset.
module keyed_ordered_queue import kyoq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  kyoq_in_if.sink     in_ch,
  kyoq_out_if.source  out_ch
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  // Key storage
  logic [KEY_W-1:0] mem [QUEUE_DEPTH];
  logic [KEY_W-1:0] rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [KEY_W-1:0] wr_data;

  // Control and payload registers
  state_t           state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  status_t          status_r, status_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [POS_W-1:0] out_pos_r, out_pos_nxt;
  logic [OCC_W-1:0] out_occ_r, out_occ_nxt;

  logic [CNT_W:0]       idx_inc;
  logic [CNT_W:0]       idx_inc2;
  logic [CNT_W:0]       cnt_ext;
  logic                 match;
  logic                 out_free;
  logic [IDX_W+POS_W-1:0] pos_wide;
  logic [CNT_W+OCC_W-1:0] occ_wide;

  assign idx_inc  = (CNT_W+1)'(idx_r) + 1'b1;
  assign idx_inc2 = (CNT_W+1)'(idx_r) + 2'd2;
  assign cnt_ext  = {1'b0, count_r};
  assign match    = (rd_data_r == key_r);
  assign out_free = !out_valid_r || out_ch.ready;
  assign pos_wide = {{POS_W{1'b0}}, pos_r};
  assign occ_wide = {{OCC_W{1'b0}}, count_r};

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.position  = out_pos_r;
  assign out_ch.occupancy = out_occ_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Sequence one operation: decode, scan, shift, deliver
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    status_nxt     = status_r;
    pos_nxt        = pos_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_occ_nxt    = out_occ_r;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = key_r;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = op_t'(in_ch.op);
          key_nxt   = {in_ch.key_high, in_ch.key_low};
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        status_nxt = ST_OK;
        pos_nxt    = '0;
        idx_nxt    = '0;
        state_nxt  = S_DONE;
        case (op_r)
          OP_APPEND: begin
            if (count_r == FULL_CNT) begin
              status_nxt = ST_FULL;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = count_r[IDX_W-1:0];
              count_nxt = count_r + 1'b1;
            end
          end
          OP_REMOVE, OP_QUERY: begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              rd_addr   = '0;
              state_nxt = S_SCAN;
            end
          end
          default: begin
            status_nxt = ST_OK;
          end
        endcase
      end

      // rd_data_r holds the entry at idx_r
      S_SCAN: begin
        if (match) begin
          pos_nxt = idx_r;
          if (op_r == OP_REMOVE) begin
            if (idx_inc < cnt_ext) begin
              rd_addr   = idx_inc[IDX_W-1:0];
              state_nxt = S_SHIFT;
            end else begin
              count_nxt = count_r - 1'b1;
              state_nxt = S_DONE;
            end
          end else begin
            state_nxt = S_DONE;
          end
        end else if (idx_inc >= cnt_ext) begin
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_DONE;
        end else begin
          rd_addr = idx_inc[IDX_W-1:0];
          idx_nxt = idx_inc[IDX_W-1:0];
        end
      end

      // rd_data_r holds the entry at idx_r + 1; move it down one place
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = rd_data_r;
        if (idx_inc2 < cnt_ext) begin
          rd_addr = idx_inc2[IDX_W-1:0];
          idx_nxt = idx_inc[IDX_W-1:0];
        end else begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_pos_nxt    = pos_wide[POS_W-1:0];
          out_occ_nxt    = occ_wide[OCC_W-1:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    idx_r        <= idx_nxt;
    status_r     <= status_nxt;
    pos_r        <= pos_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  // Occupancy never passes the queue depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("occupancy above queue depth");

  // Occupancy moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r) || count_r == $past(count_r) + 1'b1 ||
                      count_r == $past(count_r) - 1'b1))
    else $error("occupancy jumped");

  // Only a remove closes a gap
  a_shift_remove: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (op_r == OP_REMOVE))
    else $error("shift outside remove");

  // An empty result reports an empty queue
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_EMPTY) |-> (out_occ_r == '0))
    else $error("empty status with entries held");

endmodule

`default_nettype wire

[test/keyed_ordered_queue_tb.sv]
`timescale 1ns / 1ps

module keyed_ordered_queue_tb import kyoq_pkg::*;;

  localparam int QUEUE_DEPTH = 16;
  localparam int N_ITEMS     = 2000;
  localparam int POOL_SIZE   = 8;
  localparam int DRAIN_WAIT  = 3 * QUEUE_DEPTH + 8;

  // Op code that the block does not use: no change, plain ok status
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    status_t          status;
    logic [POS_W-1:0] position;
    logic [OCC_W-1:0] occupancy;
  } queue_result_t;

  // Tracks the key queue and the results owed by the block
  class kyoq_scoreboard;
    logic [KEY_W-1:0] held_keys[$];
    queue_result_t    owed_results[$];
    int               depth;
    int               errors;
    int               checked;
    int               status_tally[4];

    function new(int depth_i);
      depth = depth_i;
    endfunction

    // Apply one accepted transaction and queue its expected result
    function void note_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
      queue_result_t r;
      int            hit;
      hit         = -1;
      r.status    = ST_OK;
      r.position  = '0;
      case (op)
        OP_APPEND: begin
          if (held_keys.size() >= depth) r.status = ST_FULL;
          else held_keys.push_back(key);
        end
        OP_REMOVE, OP_QUERY: begin
          if (held_keys.size() == 0) begin
            r.status = ST_EMPTY;
          end else begin
            // match the entry nearest the head
            for (int i = 0; i < held_keys.size(); i++) begin
              if (hit < 0 && held_keys[i] == key) hit = i;
            end
            if (hit < 0) begin
              r.status = ST_NOT_FOUND;
            end else begin
              r.position = hit[POS_W-1:0];
              if (op == OP_REMOVE) held_keys.delete(hit);
            end
          end
        end
        default: ;
      endcase
      r.occupancy = OCC_W'(held_keys.size());
      owed_results.push_back(r);
    endfunction

    task report(string what);
      errors++;
      $display("%0t ns: mismatch: %s", $realtime, what);
    endtask

    // Compare one accepted result with the oldest expectation
    task check_result(logic [1:0] status, logic [POS_W-1:0] position,
                      logic [OCC_W-1:0] occupancy);
      queue_result_t exp;
      if (owed_results.size() == 0) begin
        report($sformatf("unexpected result status=%0d position=%0d occupancy=%0d",
                         status, position, occupancy));
      end else begin
        exp = owed_results.pop_front();
        checked++;
        status_tally[exp.status]++;
        if (status !== exp.status)
          report($sformatf("status %0d, want %0d", status, exp.status));
        if (position !== exp.position)
          report($sformatf("position %0d, want %0d", position, exp.position));
        if (occupancy !== exp.occupancy)
          report($sformatf("occupancy %0d, want %0d", occupancy, exp.occupancy));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  kyoq_in_if  in_ch ();
  kyoq_out_if out_ch ();

  keyed_ordered_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  kyoq_scoreboard   sb = new(QUEUE_DEPTH);
  logic [KEY_W-1:0] key_pool[POOL_SIZE];
  int               items_sent;
  bit               no_gaps;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("timeout waiting for the queue to finish");
    $display("[FAIL] regression broken");
    $finish;
  end

  // Monitor accepted transactions on both channels
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_op(in_ch.op, {in_ch.key_high, in_ch.key_low});
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.status, out_ch.position, out_ch.occupancy);
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Zero padded name of len nonzero bytes
  function automatic logic [KEY_W-1:0] make_name(int len);
    logic [KEY_W-1:0] k;
    k = '0;
    for (int i = 0; i < len; i++) k[i*8 +: 8] = 8'($urandom_range(1, 255));
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] any_key();
    return {8'($urandom_range(0, 255)), $urandom, $urandom};
  endfunction

  // Prefer keys currently held so that matches are common
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70 && sb.held_keys.size() > 0)
      return sb.held_keys[$urandom_range(0, sb.held_keys.size() - 1)];
    if (r < 88) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return any_key();
  endfunction

  // Present one transaction and hold it until accepted
  task send_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
    int gap;
    in_ch.valid    <= 1'b1;
    in_ch.op       <= op;
    in_ch.key_low  <= key[KEY_LOW_W-1:0];
    in_ch.key_high <= key[KEY_W-1:KEY_LOW_W];
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task hold_until_drained();
    in_ch.valid <= 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk);
  endtask

  // Result side: ready bursts broken by random stalls
  initial begin : sink_side
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(20, 80)) @(posedge clk);
      else repeat ($urandom_range(1, 8)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [KEY_W-1:0] k_name;
    logic [KEY_W-1:0] k_high;
    logic [KEY_W-1:0] k_tail;
    logic [KEY_W-1:0] k_last;
    int               episode;
    int               count;
    int               r;

    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.op       <= OP_APPEND;
    in_ch.key_low  <= '0;
    in_ch.key_high <= '0;
    items_sent     = 0;
    no_gaps        = 1'b0;

    // Build the key pool: short names, near misses in the high byte and
    // from the terminating zero on, and fully random keys
    for (int i = 0; i < POOL_SIZE; i++) begin
      case (i % 4)
        0: key_pool[i] = make_name($urandom_range(1, 9));
        1: key_pool[i] = key_pool[i-1] ^ {8'h01 << $urandom_range(0, 7), 64'h0};
        2: key_pool[i] = make_name(3) | (72'h1 << $urandom_range(24, 71));
        default: key_pool[i] = any_key();
      endcase
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    k_name = make_name(4);
    k_high = k_name | {8'h5a, 64'h0};
    k_tail = k_name | (72'h1 << 50);

    // Directed: empty queue, extreme keys, near misses, duplicates
    send_op(OP_QUERY, k_name);
    send_op(OP_REMOVE, k_name);
    send_op(OP_UNUSED, k_name);
    send_op(OP_APPEND, '0);
    send_op(OP_APPEND, '1);
    send_op(OP_APPEND, k_name);
    send_op(OP_APPEND, k_high);
    send_op(OP_APPEND, k_name);
    send_op(OP_QUERY, k_name);
    send_op(OP_QUERY, k_tail);
    send_op(OP_REMOVE, k_name);
    send_op(OP_QUERY, k_name);
    send_op(OP_REMOVE, '0);
    send_op(OP_UNUSED, '1);

    // Fill to the top, overflow, then hit the deepest entry
    for (int i = 0; i < QUEUE_DEPTH - 3; i++) begin
      k_last = make_name($urandom_range(1, 9));
      send_op(OP_APPEND, k_last);
    end
    send_op(OP_APPEND, k_tail);
    send_op(OP_QUERY, k_last);
    send_op(OP_REMOVE, k_last);
    send_op(OP_REMOVE, k_tail);
    hold_until_drained();

    // Random episodes: fill runs, drain runs and mixed traffic
    while (items_sent < N_ITEMS) begin
      episode = $urandom_range(0, 9);
      no_gaps = ($urandom_range(0, 4) == 0);
      if (episode < 2) begin
        count = QUEUE_DEPTH - sb.held_keys.size() + $urandom_range(1, 3);
        repeat (count) send_op(OP_APPEND, ($urandom_range(0, 3) == 0) ? any_key() :
                                          key_pool[$urandom_range(0, POOL_SIZE - 1)]);
      end else if (episode < 4) begin
        count = sb.held_keys.size() + $urandom_range(1, 2);
        repeat (count) send_op(OP_REMOVE, pick_key());
      end else begin
        repeat ($urandom_range(10, 40)) begin
          r = $urandom_range(0, 99);
          if (r < 40)      send_op(OP_APPEND, pick_key());
          else if (r < 65) send_op(OP_REMOVE, pick_key());
          else if (r < 95) send_op(OP_QUERY, pick_key());
          else             send_op(OP_UNUSED, any_key());
        end
      end
      if ($urandom_range(0, 14) == 0) hold_until_drained();
    end
    no_gaps = 1'b0;

    // Let outstanding results arrive, then allow for a stray one
    hold_until_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.owed_results.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.owed_results.size()));

    $display("checked %0d of %0d operations: %0d ok, %0d empty, %0d key missing, %0d full",
             sb.checked, items_sent, sb.status_tally[ST_OK], sb.status_tally[ST_EMPTY],
             sb.status_tally[ST_NOT_FOUND], sb.status_tally[ST_FULL]);
    $display("mismatches: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
